// File: design/lfu_pkg.sv
// Shared types and constants for the LFU cache table.
// No dependencies; imported by lfu_scan and lfu_cache_table_core.
`default_nettype none

package lfu_pkg;

    // Operation codes on s_cmd
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Capacity register
    localparam int          CAP_CFG_W = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    // Control from the sequencer to the scan unit
    typedef struct packed {
        logic start;   // clear the accumulators for a new word
        logic sample;  // an entry read from the table is on the bus
    } scan_ctrl_t;

endpackage

`default_nettype wire

// File: design/lfu_entry_ram.sv
// Entry table storage: simple dual-port synchronous RAM, registered read.
// No dependencies; instantiated by lfu_cache_table_core.
`default_nettype none

module lfu_entry_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int WIDTH = 101
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/lfu_scan.sv
// Scan unit: watches one table entry per cycle and keeps the key match,
// the eviction victim and the first free slot. Depends on lfu_pkg.
`default_nettype none

module lfu_scan
    import lfu_pkg::*;
#(
    parameter int IW = 4,
    parameter int CW = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire scan_ctrl_t    ctrl,
    input  wire logic [31:0]   key,
    input  wire logic [IW-1:0] ent_idx,
    input  wire logic          ent_valid,
    input  wire logic [31:0]   ent_key,
    input  wire logic [31:0]   ent_value,
    input  wire logic [CW-1:0] ent_count,
    input  wire logic [IW-1:0] ent_rank,
    output logic               match_found,
    output logic [IW-1:0]      match_idx,
    output logic [IW-1:0]      match_rank,
    output logic [31:0]        match_value,
    output logic               victim_found,
    output logic [IW-1:0]      victim_idx,
    output logic [IW-1:0]      victim_rank,
    output logic               free_found,
    output logic [IW-1:0]      free_idx
);

    logic [CW-1:0] victim_count_reg;
    logic          match_found_reg;
    logic          victim_found_reg;
    logic          free_found_reg;
    logic [IW-1:0] match_idx_reg;
    logic [IW-1:0] match_rank_reg;
    logic [31:0]   match_value_reg;
    logic [IW-1:0] victim_idx_reg;
    logic [IW-1:0] victim_rank_reg;
    logic [IW-1:0] free_idx_reg;
    logic          is_match;
    logic          better_victim;

    assign is_match = ctrl.sample && ent_valid && (ent_key == key) && !match_found_reg;

    // Lower count wins; on equal counts the older entry (larger rank) wins
    assign better_victim = ctrl.sample && ent_valid &&
        (!victim_found_reg || (ent_count < victim_count_reg) ||
         ((ent_count == victim_count_reg) && (ent_rank > victim_rank_reg)));

    // Found flags
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.start) begin
            match_found_reg  <= 1'b0;
            victim_found_reg <= 1'b0;
            free_found_reg   <= 1'b0;
        end else begin
            if (is_match) begin
                match_found_reg <= 1'b1;
            end
            if (better_victim) begin
                victim_found_reg <= 1'b1;
            end
            if (ctrl.sample && !ent_valid) begin
                free_found_reg <= 1'b1;
            end
        end
    end

    // Captured entry data
    always_ff @(posedge aclk) begin
        if (is_match) begin
            match_idx_reg   <= ent_idx;
            match_rank_reg  <= ent_rank;
            match_value_reg <= ent_value;
        end
        if (better_victim) begin
            victim_idx_reg   <= ent_idx;
            victim_rank_reg  <= ent_rank;
            victim_count_reg <= ent_count;
        end
        if (ctrl.sample && !ent_valid && !free_found_reg) begin
            free_idx_reg <= ent_idx;
        end
    end

    assign match_found  = match_found_reg;
    assign match_idx    = match_idx_reg;
    assign match_rank   = match_rank_reg;
    assign match_value  = match_value_reg;
    assign victim_found = victim_found_reg;
    assign victim_idx   = victim_idx_reg;
    assign victim_rank  = victim_rank_reg;
    assign free_found   = free_found_reg;
    assign free_idx     = free_idx_reg;

endmodule

`default_nettype wire

// File: design/lfu_cache_table_core.sv
// LFU cache table: channels, operation sequencer and entry update logic.
// Depends on lfu_pkg, lfu_entry_ram and lfu_scan.
//
// Usage:
//   Input words (s_cmd, s_lookup_key, s_put_value) enter on s_valid/s_ready.
//   A get returns one result word (m_hit, m_read_value) on m_valid/m_ready;
//   a put returns nothing. m_read_value is zero on a miss.
//   cfg_wr_en/cfg_wr_data write the capacity register (reset 16); values
//   above CAPACITY act as CAPACITY, zero makes every put a no-op.
// Sequence:
//   Each word first sweeps the whole entry RAM (one entry per cycle, one
//   read port, registered read), then passes the decide state. A hit or a
//   stored put then does a read-modify-write sweep of the whole RAM to
//   update counts and recency ranks.
//   s_ready stays low from the accept until the word is done, so no new
//   word is taken meanwhile: a get miss or an ignored put ends in the
//   decide state, a hit or a stored put at the end of its update sweep.
//   A get result appears in the output register right after the decide cycle.
// Reset and stall:
//   After aresetn the RAM is cleared one entry per cycle;
//   s_ready stays low meanwhile; configuration writes are taken at any time.
//   The output register holds a word until taken; the next word is accepted
//   and processed meanwhile, and waits in its decide state only if it is a
//   get whose result finds the output register still full.
`default_nettype none

module lfu_cache_table_core
    import lfu_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,
    // input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_cmd,
    input  wire logic [31:0] s_lookup_key,
    input  wire logic [31:0] s_put_value,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_hit,
    output logic [31:0]      m_read_value
);

    localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int HW    = $clog2(CAPACITY + 1);
    localparam int CMPW  = (HW > CAP_CFG_W) ? HW : CAP_CFG_W;
    localparam int CW    = COUNT_WIDTH;
    localparam int WORDW = 1 + 32 + 32 + CW + IW;
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DECIDE = 5'b01000,
        ST_UPDATE = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   ptr_reg, ptr_next;
    logic            issue_reg, issue_next;
    logic            pend_reg;
    logic            pend_last_reg;
    logic [IW-1:0]   pend_idx_reg;
    logic [4:0]      cap_reg;
    logic [HW-1:0]   held_reg, held_next;
    logic            cmd_reg;
    logic [31:0]     key_reg;
    logic [31:0]     val_reg;
    logic            insert_reg, insert_next;
    logic            evict_reg, evict_next;
    logic [IW-1:0]   tgt_idx_reg, tgt_idx_next;
    logic [IW-1:0]   tgt_rank_reg, tgt_rank_next;
    logic [IW-1:0]   vic_idx_reg, vic_idx_next;
    logic [IW-1:0]   vic_rank_reg, vic_rank_next;
    logic            m_valid_reg, m_valid_next;
    logic            m_hit_reg, m_hit_next;
    logic [31:0]     m_value_reg, m_value_next;

    logic            in_accept;
    logic            rd_en;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    logic [WORDW-1:0] wr_data;
    logic [WORDW-1:0] rd_data;
    logic            out_busy;

    // Entry fields of the word coming out of the RAM
    logic            ent_valid;
    logic [31:0]     ent_key;
    logic [31:0]     ent_value;
    logic [CW-1:0]   ent_count;
    logic [IW-1:0]   ent_rank;

    // Scan results
    scan_ctrl_t      scan_ctrl;
    logic            sc_match_found;
    logic [IW-1:0]   sc_match_idx;
    logic [IW-1:0]   sc_match_rank;
    logic [31:0]     sc_match_value;
    logic            sc_victim_found;
    logic [IW-1:0]   sc_victim_idx;
    logic [IW-1:0]   sc_victim_rank;
    logic            sc_free_found;
    logic [IW-1:0]   sc_free_idx;

    // Decide-cycle terms
    logic [CMPW-1:0] cap_ext;
    logic [CMPW-1:0] cap_eff;
    logic            cap_zero;
    logic            full;

    // Updated entry fields
    logic            upd_valid;
    logic [31:0]     upd_key;
    logic [31:0]     upd_value;
    logic [CW-1:0]   upd_count;
    logic [IW-1:0]   upd_rank;

    assign in_accept = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_busy  = m_valid_reg && !m_ready;

    assign ent_valid = rd_data[WORDW-1];
    assign ent_key   = rd_data[WORDW-2 -: 32];
    assign ent_value = rd_data[WORDW-34 -: 32];
    assign ent_count = rd_data[IW +: CW];
    assign ent_rank  = rd_data[0 +: IW];

    // Effective capacity
    assign cap_ext  = CMPW'(cap_reg);
    assign cap_eff  = (cap_ext > CMPW'(CAPACITY)) ? CMPW'(CAPACITY) : cap_ext;
    assign cap_zero = (cap_eff == '0);
    assign full     = (CMPW'(held_reg) >= cap_eff);

    // RAM read side: one entry per cycle while a sweep is issuing
    assign rd_en = issue_reg && ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE));

    assign scan_ctrl.start  = in_accept;
    assign scan_ctrl.sample = (state_reg == ST_SCAN) && pend_reg;

    lfu_entry_ram #(
        .DEPTH (CAPACITY),
        .AW    (IW),
        .WIDTH (WORDW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    lfu_scan #(
        .IW (IW),
        .CW (CW)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (scan_ctrl),
        .key          (key_reg),
        .ent_idx      (pend_idx_reg),
        .ent_valid    (ent_valid),
        .ent_key      (ent_key),
        .ent_value    (ent_value),
        .ent_count    (ent_count),
        .ent_rank     (ent_rank),
        .match_found  (sc_match_found),
        .match_idx    (sc_match_idx),
        .match_rank   (sc_match_rank),
        .match_value  (sc_match_value),
        .victim_found (sc_victim_found),
        .victim_idx   (sc_victim_idx),
        .victim_rank  (sc_victim_rank),
        .free_found   (sc_free_found),
        .free_idx     (sc_free_idx)
    );

    // Per-entry read-modify-write during the update sweep
    always_comb begin
        upd_valid = ent_valid;
        upd_key   = ent_key;
        upd_value = ent_value;
        upd_count = ent_count;
        upd_rank  = ent_rank;
        if (!insert_reg) begin
            // touch: target goes to rank 0, newer entries age by one
            if (pend_idx_reg == tgt_idx_reg) begin
                upd_rank = '0;
                if (ent_count != {CW{1'b1}}) begin
                    upd_count = ent_count + 1'b1;
                end
                if (cmd_reg == CMD_PUT) begin
                    upd_value = val_reg;
                end
            end else if (ent_valid && (ent_rank < tgt_rank_reg)) begin
                upd_rank = ent_rank + 1'b1;
            end
        end else begin
            // insert, with optional eviction of the victim
            if (pend_idx_reg == tgt_idx_reg) begin
                upd_valid = 1'b1;
                upd_key   = key_reg;
                upd_value = val_reg;
                upd_count = CW'(1);
                upd_rank  = '0;
            end else if (evict_reg && (pend_idx_reg == vic_idx_reg)) begin
                upd_valid = 1'b0;
            end else if (ent_valid && !(evict_reg && (ent_rank > vic_rank_reg))) begin
                upd_rank = ent_rank + 1'b1;
            end
        end
    end

    // RAM write side: clearing pass or update write-back
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = ptr_reg;
            wr_data = '0;
        end else begin
            wr_en   = (state_reg == ST_UPDATE) && pend_reg;
            wr_addr = pend_idx_reg;
            wr_data = {upd_valid, upd_key, upd_value, upd_count, upd_rank};
        end
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        issue_next    = issue_reg;
        held_next     = held_reg;
        insert_next   = insert_reg;
        evict_next    = evict_reg;
        tgt_idx_next  = tgt_idx_reg;
        tgt_rank_next = tgt_rank_reg;
        vic_idx_next  = vic_idx_reg;
        vic_rank_next = vic_rank_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_hit_next    = m_hit_reg;
        m_value_next  = m_value_reg;

        // address walk shared by all sweeps
        if (rd_en) begin
            if (ptr_reg == LAST_IDX) begin
                issue_next = 1'b0;
            end else begin
                ptr_next = ptr_reg + 1'b1;
            end
        end

        unique case (state_reg)
            ST_CLEAR: begin
                if (ptr_reg == LAST_IDX) begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    ptr_next   = '0;
                    issue_next = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (pend_reg && pend_last_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (cmd_reg == CMD_GET) begin
                    if (!out_busy) begin
                        m_valid_next = 1'b1;
                        m_hit_next   = sc_match_found;
                        m_value_next = sc_match_found ? sc_match_value : '0;
                        if (sc_match_found) begin
                            insert_next   = 1'b0;
                            tgt_idx_next  = sc_match_idx;
                            tgt_rank_next = sc_match_rank;
                            ptr_next      = '0;
                            issue_next    = 1'b1;
                            state_next    = ST_UPDATE;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end else if (cap_zero) begin
                    state_next = ST_IDLE;
                end else if (sc_match_found) begin
                    insert_next   = 1'b0;
                    tgt_idx_next  = sc_match_idx;
                    tgt_rank_next = sc_match_rank;
                    ptr_next      = '0;
                    issue_next    = 1'b1;
                    state_next    = ST_UPDATE;
                end else begin
                    // new key: evict when full; slot is the lowest free index, or the victim if lower or none is free
                    insert_next   = 1'b1;
                    evict_next    = full;
                    vic_idx_next  = sc_victim_idx;
                    vic_rank_next = sc_victim_rank;
                    if (full && (!sc_free_found || (sc_victim_idx < sc_free_idx))) begin
                        tgt_idx_next = sc_victim_idx;
                    end else begin
                        tgt_idx_next = sc_free_idx;
                    end
                    if (!full) begin
                        held_next = held_reg + 1'b1;
                    end
                    ptr_next   = '0;
                    issue_next = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (pend_reg && pend_last_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            held_reg      <= '0;
            cap_reg       <= CAP_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            issue_reg     <= issue_next;
            pend_reg      <= rd_en;
            pend_last_reg <= rd_en && (ptr_reg == LAST_IDX);
            held_reg      <= held_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pend_idx_reg <= ptr_reg;
        insert_reg   <= insert_next;
        evict_reg    <= evict_next;
        tgt_idx_reg  <= tgt_idx_next;
        tgt_rank_reg <= tgt_rank_next;
        vic_idx_reg  <= vic_idx_next;
        vic_rank_reg <= vic_rank_next;
        m_hit_reg    <= m_hit_next;
        m_value_reg  <= m_value_next;
        if (in_accept) begin
            cmd_reg <= s_cmd;
            key_reg <= s_lookup_key;
            val_reg <= s_put_value;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_read_value = m_value_reg;

`ifndef SYNTHESIS
    // The entry count never exceeds the table
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMPW'(held_reg) <= CMPW'(CAPACITY))
        else $error("entry count above table size");

    // Write-back never hits the entry being read in the same cycle
    a_rmw_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != ptr_reg))
        else $error("RAM read and write to the same entry");

    // A new key always has a slot: a free entry or an evicted one
    a_insert_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DECIDE) && (cmd_reg == CMD_PUT) && !cap_zero && !sc_match_found)
        |-> (sc_free_found || (full && sc_victim_found)))
        else $error("insert without a slot");
`endif

endmodule

`default_nettype wire

// File: sim/tb_lfu_cache_table_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for lfu_cache_table_core: a scoreboard class predicts
// every get result of the LFU cache; tasks drive words and capacity writes.
// Depends on lfu_pkg and the lfu_cache_table_core RTL.

module tb_lfu_cache_table_core;
    import lfu_pkg::*;

    localparam int CAP   = 16;
    localparam int CNT_W = 32;

    typedef struct packed {
        logic        hit;
        logic [31:0] data;
    } lookup_result_t;

    // Predicts the table contents and holds the expected get results in order
    class lfu_scoreboard;
        bit               live   [CAP];
        logic [31:0]      key_of [CAP];
        logic [31:0]      val_of [CAP];
        logic [CNT_W-1:0] uses   [CAP];
        int               rank   [CAP];
        int               held;
        logic [4:0]       cap_reg;
        lookup_result_t   pending[$];
        int errors, gets, puts, results, hits, evictions, cap_writes;

        function new();
            for (int i = 0; i < CAP; i++) begin
                live[i] = 1'b0;
                rank[i] = 0;
            end
            held       = 0;
            cap_reg    = CAP_RESET;
            errors     = 0;
            gets       = 0;
            puts       = 0;
            results    = 0;
            hits       = 0;
            evictions  = 0;
            cap_writes = 0;
        endfunction

        function void set_capacity(logic [4:0] v);
            cap_reg = v;
            cap_writes++;
        endfunction

        function int find_slot(logic [31:0] k);
            for (int i = 0; i < CAP; i++)
                if (live[i] && key_of[i] == k)
                    return i;
            return -1;
        endfunction

        // Entry becomes most recent and counts one more use (saturating)
        function void bump(int s);
            for (int i = 0; i < CAP; i++)
                if (live[i] && rank[i] < rank[s])
                    rank[i]++;
            rank[s] = 0;
            if (uses[s] != {CNT_W{1'b1}})
                uses[s]++;
        endfunction

        function void note_input(logic cmd, logic [31:0] k, logic [31:0] v);
            int             s;
            int             vic;
            int             slot;
            int             eff;
            lookup_result_t r;
            eff = (cap_reg > CAP) ? CAP : int'(cap_reg);
            s   = find_slot(k);
            if (cmd == CMD_GET) begin
                gets++;
                if (s >= 0) begin
                    r.hit  = 1'b1;
                    r.data = val_of[s];
                    bump(s);
                end else begin
                    r.hit  = 1'b0;
                    r.data = '0;
                end
                pending.push_back(r);
                return;
            end
            puts++;
            if (eff == 0)
                return;
            if (s >= 0) begin
                val_of[s] = v;
                bump(s);
                return;
            end
            // Full (or over a lowered capacity): evict lowest count, oldest on a tie
            if (held >= eff) begin
                vic = -1;
                for (int i = 0; i < CAP; i++) begin
                    if (!live[i])
                        continue;
                    if (vic < 0 || uses[i] < uses[vic] ||
                        (uses[i] == uses[vic] && rank[i] > rank[vic]))
                        vic = i;
                end
                if (vic >= 0) begin
                    live[vic] = 1'b0;
                    for (int i = 0; i < CAP; i++)
                        if (live[i] && rank[i] > rank[vic])
                            rank[i]--;
                    if (held > 0)
                        held--;
                    evictions++;
                end
            end
            slot = -1;
            for (int i = 0; i < CAP; i++) begin
                if (!live[i]) begin
                    slot = i;
                    break;
                end
            end
            if (slot < 0)
                return;
            for (int i = 0; i < CAP; i++)
                if (live[i])
                    rank[i]++;
            live[slot]   = 1'b1;
            key_of[slot] = k;
            val_of[slot] = v;
            uses[slot]   = 1;
            rank[slot]   = 0;
            held++;
        endfunction

        function void check_result(logic hit, logic [31:0] data);
            lookup_result_t exp_r;
            results++;
            if (hit)
                hits++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("MISMATCH result %0d: none expected, got hit=%0b value=%h",
                             results, hit, data);
                return;
            end
            exp_r = pending.pop_front();
            if (hit !== exp_r.hit || data !== exp_r.data) begin
                errors++;
                if (errors <= 10)
                    $display("MISMATCH result %0d: expected hit=%0b value=%h, got hit=%0b value=%h",
                             results, exp_r.hit, exp_r.data, hit, data);
            end
        endfunction

        function void final_check();
            if (pending.size() != 0) begin
                errors += pending.size();
                $display("MISMATCH: %0d expected results never arrived", pending.size());
            end
        endfunction
    endclass

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [4:0]  cfg_wr_data  = '0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic        s_cmd        = CMD_GET;
    logic [31:0] s_lookup_key = '0;
    logic [31:0] s_put_value  = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic        m_hit;
    logic [31:0] m_read_value;

    lfu_scoreboard sb = new();
    bit            in_burst = 1'b0;

    lfu_cache_table_core #(
        .CAPACITY    (CAP),
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_lookup_key (s_lookup_key),
        .s_put_value  (s_put_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_read_value (m_read_value)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offer one word after a random gap; returns at the accepting edge
    task automatic send_word(input logic cmd, input logic [31:0] key, input logic [31:0] val);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_lookup_key <= key;
        s_put_value  <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(cmd, key, val);
    endtask

    // Drain: no word offered, all results taken, then cover a full update sweep
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (2 * CAP + 8) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [4:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_capacity(v);
    endtask

    // Result side: random stall before each word, with stall-free stretches
    initial begin
        int stall;
        int taken;
        bit out_burst;
        taken     = 0;
        out_burst = 1'b0;
        forever begin
            if (taken % 16 == 0)
                out_burst = ($urandom_range(0, 3) == 0);
            stall = out_burst ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
            taken++;
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_hit, m_read_value);
    end

    // Stimulus
    initial begin
        logic [4:0]  phase_caps [10];
        logic [31:0] pool [24];
        int          pool_n;
        int          eff;
        int          pick;
        logic        cmd;
        logic [31:0] key;

        phase_caps = '{5'd31, 5'd1, 5'd5, 5'd16, 5'd0,
                       5'd17, 5'd3, 5'd8, 5'd12, 5'd16};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty miss, extreme keys and values, hits, update in place
        send_word(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_word(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(CMD_PUT, 32'h0000_0000, 32'h1234_5678);
        send_word(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_GET, 32'h0000_0001, 32'h0000_0000);

        // Capacity lowered below the entries held; then a tie on use count
        write_capacity(5'd2);
        send_word(CMD_PUT, 32'd100, 32'hA5A5_0100);
        send_word(CMD_PUT, 32'd101, 32'hA5A5_0101);
        send_word(CMD_GET, 32'd100, 32'h0000_0000);
        send_word(CMD_GET, 32'd101, 32'h0000_0000);
        send_word(CMD_PUT, 32'd102, 32'hA5A5_0102);
        send_word(CMD_GET, 32'd100, 32'h0000_0000);
        send_word(CMD_GET, 32'h0000_0000, 32'h0000_0000);

        // Capacity zero: puts ignored, present entries still hit
        write_capacity(5'd0);
        send_word(CMD_PUT, 32'd103, 32'hDEAD_BEEF);
        send_word(CMD_PUT, 32'd101, 32'hDEAD_BEEF);
        send_word(CMD_GET, 32'd101, 32'h0000_0000);
        send_word(CMD_GET, 32'd103, 32'h0000_0000);

        // Random phases over several capacities, keys mostly from a small pool
        for (int p = 0; p < 10; p++) begin
            write_capacity(phase_caps[p]);
            eff    = (phase_caps[p] > CAP) ? CAP : int'(phase_caps[p]);
            pool_n = eff + $urandom_range(1, 5);
            if (pool_n > 24)
                pool_n = 24;
            for (int j = 0; j < pool_n; j++)
                pool[j] = $urandom;
            for (int i = 0; i < 125; i++) begin
                if (i % 32 == 0)
                    in_burst = ($urandom_range(0, 3) == 0);
                cmd = ($urandom_range(0, 99) < 55) ? CMD_GET : CMD_PUT;
                if ($urandom_range(0, 9) == 0) begin
                    key = $urandom;
                end else begin
                    // skew toward low pool indexes so counts spread out
                    pick = $urandom_range(0, pool_n - 1);
                    if ($urandom_range(0, 1) == 1)
                        pick = pick / 2;
                    key = pool[pick];
                end
                send_word(cmd, key, $urandom);
            end
        end

        settle();
        sb.final_check();
        $display("Covered %0d words (%0d gets, %0d puts) over %0d capacity writes.",
                 sb.gets + sb.puts, sb.gets, sb.puts, sb.cap_writes);
        $display("Checked %0d results: %0d hits, %0d predicted evictions, %0d errors.",
                 sb.results, sb.hits, sb.evictions, sb.errors);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
